// ----- design/rtid_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_pkg
// shared types and constants for the double round-to-integral pipeline
// ----------------------------------------------------------------------------
package rtid_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned FracWidth = 52;
   localparam int unsigned ExpWidth  = 11;
   localparam int unsigned FuncWidth = 2;
   localparam int unsigned ShiftWidth = 6;

   localparam logic [ExpWidth-1:0] ExpAllOnes = 11'h7FF;
   localparam logic [ExpWidth-1:0] ExpBias    = 11'd1023;
   localparam logic [11:0]         ExpInt     = 12'd1075;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_FLOOR = 2'd0,
      FUNC_CEIL  = 2'd1,
      FUNC_RINT  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // decoded operand passed from stage 1 to stage 2
   typedef struct packed {
      logic                    pass;
      logic                    sign;
      logic                    below_half;   // magnitude below one half
      func_type                func;
      logic [ShiftWidth-1:0]   shift;        // 1..53 when neither pass nor below_half
      logic [FracWidth:0]      mant;
      logic [DataWidth-1:0]    operand;
   } dec_type;

   // rounded integer passed from stage 2 to stage 3
   typedef struct packed {
      logic                    pass;
      logic                    sign;
      logic                    rint;
      logic [FracWidth:0]      n;       // at most 2^52
      logic [DataWidth-1:0]    operand;
   } int_type;

endpackage
`default_nettype wire

// ----- design/rtid_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_if
// valid/ready channel carrying one payload of generic type
// ----------------------------------------------------------------------------
interface rtid_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/rtid_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_decode
// unpacks the operand and works out the rounding shift
// ----------------------------------------------------------------------------
module rtid_decode (
   input  wire logic [rtid_pkg::FuncWidth-1:0] func,
   input  wire logic [rtid_pkg::DataWidth-1:0] operand,
   output rtid_pkg::dec_type                   dec
);
   import rtid_pkg::*;

   logic [ExpWidth-1:0] exp_raw;
   logic [11:0]         exp_eff;
   logic [11:0]         shift_full;

   // field split and classification
   always_comb begin
      exp_raw    = operand[62:52];
      exp_eff    = (exp_raw == '0) ? 12'd1 : {1'b0, exp_raw};
      shift_full = ExpInt - exp_eff;
      dec.func    = func_type'(func);
      dec.sign    = operand[63];
      dec.operand = operand;
      dec.mant    = {(exp_raw != '0), operand[51:0]};
      dec.pass    = (func == FUNC_NONE) || ({1'b0, exp_raw} >= ExpInt);
      dec.below_half = (shift_full >= 12'd54);
      dec.shift   = shift_full[ShiftWidth-1:0];
   end
endmodule
`default_nettype wire

// ----- design/rtid_round.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_round
// truncates the mantissa and applies the rounding increment
// ----------------------------------------------------------------------------
module rtid_round (
   input  wire rtid_pkg::dec_type dec,
   output rtid_pkg::int_type      res
);
   import rtid_pkg::*;

   logic [FracWidth:0] mask;
   logic [FracWidth:0] trunc;
   logic [FracWidth:0] rem;
   logic [FracWidth:0] half;
   logic               frac;
   logic               inc;

   // split into integer part and remainder, then apply the rounding increment
   always_comb begin
      mask  = ({(FracWidth+1){1'b1}} << dec.shift);
      if (dec.below_half) begin
         trunc = '0;
         rem   = dec.mant;
         half  = '0;
      end else begin
         trunc = dec.mant >> dec.shift;
         rem   = dec.mant & ~mask;
         half  = (FracWidth+1)'(1) << (dec.shift - 6'd1);
      end
      frac = (rem != '0);
      case (dec.func)
         FUNC_FLOOR: inc = frac && dec.sign;
         FUNC_CEIL:  inc = frac && !dec.sign;
         FUNC_RINT:  inc = !dec.below_half && ((rem > half) || ((rem == half) && trunc[0]));
         default:    inc = 1'b0;
      endcase
      res.n       = trunc + (FracWidth+1)'(inc);
      res.pass    = dec.pass;
      res.sign    = dec.sign;
      res.rint    = (dec.func == FUNC_RINT);
      res.operand = dec.operand;
   end
endmodule
`default_nettype wire

// ----- design/rtid_pack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_pack
// normalizes the integer back into a double
// ----------------------------------------------------------------------------
module rtid_pack (
   input  wire rtid_pkg::int_type              res,
   output logic [rtid_pkg::DataWidth-1:0]      rounded
);
   import rtid_pkg::*;

   logic [5:0]         msb;
   logic [FracWidth:0] norm;

   // leading one position, then assembly of the rounded double
   always_comb begin
      msb = '0;
      for (int i = 0; i <= FracWidth; i++) begin
         if (res.n[i]) msb = 6'(i);
      end
      norm = res.n << (6'(FracWidth) - msb);
      if (res.pass) begin
         rounded = res.operand;
      end else if (res.n == '0) begin
         rounded = {(res.sign && !res.rint), 63'd0};
      end else begin
         rounded = {res.sign, ExpBias + {5'd0, msb}, norm[FracWidth-1:0]};
      end
   end
endmodule
`default_nettype wire

// ----- design/round_to_integral_double_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// round_to_integral_double_top
// floor, ceil and round-to-nearest-even of an IEEE 754 double
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output is free or taken. The
// accepting edge loads the input register; the decode and round registers
// load after it, in that order, and then the output register takes the
// packed double. Valid bits travel with the data and the whole pipe
// advances whenever the output is free or taken, so sustained throughput
// is one transaction per cycle. NaN, infinities, values of at least 2^52
// and func 3 return the operand unchanged.
module round_to_integral_double_top (
   input wire logic clock,
   input wire logic reset,
   rtid_if.sink     req,
   rtid_if.source   rsp
);
   import rtid_pkg::*;

   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    v1_in, v2_in, v3_in, v4_in;
   logic    advance;
   logic [FuncWidth-1:0] func_ff;
   logic [DataWidth-1:0] op_ff;
   dec_type dec_c, dec_ff;
   int_type int_c, int_ff;
   logic [DataWidth-1:0] rnd_c, out_ff;

   // pipe moves when output slot is empty or taken
   assign advance = !v4_ff || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = v4_ff;
   assign rsp.data  = out_ff;

   assign v1_in = advance ? (req.valid) : v1_ff;
   assign v2_in = advance ? v1_ff : v2_ff;
   assign v3_in = advance ? v2_ff : v3_ff;
   assign v4_in = advance ? v3_ff : v4_ff;

   rtid_decode u_decode (.func(func_ff), .operand(op_ff), .dec(dec_c));
   rtid_round  u_round  (.dec(dec_ff), .res(int_c));
   rtid_pack   u_pack   (.res(int_ff), .rounded(rnd_c));

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         func_ff <= req.data[DataWidth+FuncWidth-1:DataWidth];
         op_ff   <= req.data[DataWidth-1:0];
         dec_ff  <= dec_c;
         int_ff  <= int_c;
         out_ff  <= rnd_c;
      end
   end

`ifndef ASSERT_OFF
   // a held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   // input is taken whenever the output is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipeline stalled with free output");
   // an accepted transaction sets the input register valid next cycle
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v1_ff)
      else $error("accepted transaction lost");
`endif
endmodule
`default_nettype wire

// ----- tb/rtid_tb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_tb_pkg
// request payload type shared by the testbench top and the checker
// ----------------------------------------------------------------------------
package rtid_tb_pkg;
   import rtid_pkg::*;

   typedef struct packed {
      func_type              func;
      logic [DataWidth-1:0]  operand;
   } req_type;

endpackage
`default_nettype wire

// ----- tb/rtid_tb_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_tb_if
// the channel interface itself lives with the design; this file only
// provides the response payload type used to instantiate it
// ----------------------------------------------------------------------------
package rtid_tb_rsp_pkg;
   typedef logic [63:0] rsp_type;
endpackage
`default_nettype wire

// ----- tb/rtid_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtid_checker
// watches both channels, predicts each rounded double and compares in order
// ----------------------------------------------------------------------------
module rtid_checker
   import rtid_pkg::*;
   import rtid_tb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [DataWidth-1:0] rsp_data,
   output int                        errors,
   output int                        pending,
   output int                        checked
);

   logic [DataWidth-1:0] expected_rounded[$];

   // build a double from sign and integer magnitude (magnitude <= 2^52)
   function automatic logic [63:0] pack_integer(logic sign, logic [63:0] n);
      int msb;
      logic [63:0] shifted;
      msb = 0;
      if (n == 0) return {sign, 63'd0};
      for (int i = 0; i < 64; i++) if (n[i]) msb = i;
      shifted = n << (52 - msb);
      return {sign, 11'(1023 + msb), shifted[51:0]};
   endfunction

   // floor, ceil or round-half-even of one double bit pattern
   function automatic logic [63:0] round_double(func_type f, logic [63:0] x);
      logic        sign;
      int          expo;
      int          shift;
      logic [63:0] mant, trunc, rem, half, n;
      logic        frac, below_half;
      sign = x[63];
      expo = int'(x[62:52]);
      mant = {12'd0, x[51:0]};
      if (f == FUNC_NONE || expo == 2047 || expo >= 1075) return x;
      if (expo != 0) mant[52] = 1'b1;
      else expo = 1;
      shift = 1075 - expo;
      below_half = (shift >= 54);
      if (below_half) begin
         trunc = 0;
         rem   = mant;
         half  = 0;
      end else begin
         trunc = mant >> shift;
         rem   = mant & ((64'd1 << shift) - 64'd1);
         half  = 64'd1 << (shift - 1);
      end
      frac = (rem != 0);
      case (f)
         FUNC_FLOOR: begin
            return pack_integer(sign, trunc + ((frac && sign) ? 64'd1 : 64'd0));
         end
         FUNC_CEIL: begin
            return pack_integer(sign, trunc + ((frac && !sign) ? 64'd1 : 64'd0));
         end
         default: begin
            n = trunc;
            if (!below_half && (rem > half || (rem == half && trunc[0]))) n = trunc + 1;
            if (n == 0) return 64'd0;
            return pack_integer(sign, n);
         end
      endcase
   endfunction

   // predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      logic [DataWidth-1:0] want;
      if (reset) begin
         errors  <= 0;
         checked <= 0;
         pending <= 0;
         expected_rounded.delete();
      end else begin
         if (req_valid && req_ready)
            expected_rounded.push_back(round_double(req_data.func, req_data.operand));
         if (rsp_valid && rsp_ready) begin
            if (expected_rounded.size() == 0) begin
               $display("%0t: unexpected result rounded=%h", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_rounded.pop_front();
               checked <= checked + 1;
               if (want !== rsp_data) begin
                  $display("%0t: rounded mismatch expected=%h actual=%h",
                           $time, want, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
         pending <= expected_rounded.size();
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb_round_to_integral_double_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_round_to_integral_double_top
// stimulus and verdict for the double round-to-integral pipeline
// ----------------------------------------------------------------------------
// Directed corner operands for every operation, then random doubles weighted
// toward the fractional range, ties and specials. Sender bursts and receiver
// stalls vary; the checker predicts every result and counts mismatches.
module tb_round_to_integral_double_top;
   import rtid_pkg::*;
   import rtid_tb_pkg::*;
   import rtid_tb_rsp_pkg::*;

   localparam int WatchdogLimit = 5000;
   localparam int NumRandom     = 500;

   logic clock;
   logic reset;
   int   errors, pending, checked, sent, idle_cycles;
   bit   timed_out;

   rtid_if #(.payload_type(req_type)) req ();
   rtid_if #(.payload_type(rsp_type)) rsp ();

   round_to_integral_double_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   rtid_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_data  (req.data),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_data  (rsp.data),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stall pattern: modes of always-ready, random and sparse
   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      static int mode = 0;
      static int left = 0;
      if (left == 0) begin
         mode = $urandom_range(0, 2);
         left = $urandom_range(5, 60);
      end
      left = left - 1;
      case (mode)
         0:       rsp.ready <= 1'b1;
         1:       rsp.ready <= $urandom_range(0, 1);
         default: rsp.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("FAIL");
         $finish;
      end
   end

   // one request transaction; valid stays high for the caller's next item
   task automatic send_item(func_type f, logic [63:0] x);
      req.valid     <= 1'b1;
      req.data.func <= f;
      req.data.operand <= x;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   // random gap between bursts
   task automatic maybe_gap();
      int gap;
      if ($urandom_range(0, 3) != 0) return;
      gap = $urandom_range(1, 8);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // random operand weighted toward values that actually round
   function automatic logic [63:0] random_operand();
      logic [63:0] x;
      int          expo, shift;
      x = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: x[62:52] = 11'h7FF;                              // inf or nan
         1: x[62:52] = 11'd0;                                // subnormal or zero
         2: x[62:52] = 11'($urandom_range(1075, 2046));      // already integral
         3: x[62:0]  = 63'd0;                                // signed zero
         4, 5: begin                                         // exact ties
            expo = $urandom_range(1022, 1074);
            x[62:52] = 11'(expo);
            shift = 1075 - expo;
            x[51:0] = x[51:0] & ~((52'd1 << (shift - 1)) - 52'd1);
            if (shift <= 52) x[shift-1] = 1'b1;
         end
         default: x[62:52] = 11'($urandom_range(1010, 1076));
      endcase
      return x;
   endfunction

   initial begin
      logic [63:0] corners[$];
      timed_out   = 1'b0;
      sent        = 0;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.data    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: zeros, halves, ties, subnormals, specials, limits
      corners = '{64'h0000000000000000, 64'h8000000000000000, 64'h3FE0000000000000,
                  64'hBFE0000000000000, 64'h3FF8000000000000, 64'hC004000000000000,
                  64'hBFD3333333333333, 64'h0000000000000001, 64'h800FFFFFFFFFFFFF,
                  64'h7FF0000000000000, 64'hFFF8000000000001, 64'h4330000000000000,
                  64'h432FFFFFFFFFFFFF, 64'hC32FFFFFFFFFFFFF, 64'h3FEFFFFFFFFFFFFF,
                  64'h7FEFFFFFFFFFFFFF};
      foreach (corners[i]) begin
         send_item(FUNC_FLOOR, corners[i]);
         if (i % 3 == 0) send_item(FUNC_CEIL, corners[i]);
         if (i % 3 == 1) send_item(FUNC_RINT, corners[i]);
      end
      send_item(FUNC_NONE, 64'h3FF8000000000000);
      send_item(FUNC_CEIL, 64'hFFFFFFFFFFFFFFFF);

      // random part in bursts; at the midpoint drain the pipe completely
      for (int k = 0; k < NumRandom; k++) begin
         if (k == NumRandom / 2) begin
            req.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_item(func_type'($urandom_range(0, 3)), random_operand());
         maybe_gap();
      end
      req.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d operands across floor, ceil, rint and pass-through; %0d results checked",
               sent, checked);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
